// ===== design/bmp4_pkg.sv =====
// shared types, constants and helpers of the 4-bit palette bmp decoder
package bmp4_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned PAL_ENTRIES = 16;
  localparam int unsigned PAL_AW = $clog2(PAL_ENTRIES);

  localparam logic [15:0] MAGIC_WORD = 16'h4D42;
  localparam logic [15:0] BIT_COUNT = 16'd4;
  localparam logic [31:0] PAL_START = 32'd54;
  localparam logic [31:0] HEADER_END = 32'd118;

  localparam logic [2:0] KIND_PIXEL = 3'd0;
  localparam logic [2:0] KIND_BAD_MAGIC = 3'd1;
  localparam logic [2:0] KIND_BAD_DEPTH = 3'd2;
  localparam logic [2:0] KIND_BAD_SIZE = 3'd3;
  localparam logic [2:0] KIND_BAD_OFFSET = 3'd4;

  localparam logic [1:0] COMP_BLUE = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;
  localparam logic [1:0] COMP_RED = 2'd2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    rgb_t        color;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        run_last;
    logic        image_last;
  } res_t;

  typedef struct packed {
    logic              clr;
    logic              en;
    logic [1:0]        comp;
    logic [PAL_AW-1:0] idx;
    logic [7:0]        data;
  } pal_wr_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic       free;
  } buf_stat_t;

  function automatic logic dim_ok(input logic [31:0] v);
    dim_ok = (v != 32'd0) && !v[31] && (v <= 32'(MAX_DIM));
  endfunction

endpackage

// ===== design/bmp4_palette.sv =====
// 16-entry palette, one component byte written at a time, two registered reads
module bmp4_palette (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bmp4_pkg::pal_wr_t            wr,
  input  logic                         rd_en,
  input  logic [bmp4_pkg::PAL_AW-1:0]  rd_addr_hi,
  input  logic [bmp4_pkg::PAL_AW-1:0]  rd_addr_lo,
  output bmp4_pkg::rgb_t               rd_hi,
  output bmp4_pkg::rgb_t               rd_lo
);

  logic [7:0] red_mem [bmp4_pkg::PAL_ENTRIES];
  logic [7:0] grn_mem [bmp4_pkg::PAL_ENTRIES];
  logic [7:0] blu_mem [bmp4_pkg::PAL_ENTRIES];

  logic [bmp4_pkg::PAL_ENTRIES-1:0] red_vld_r;
  logic [bmp4_pkg::PAL_ENTRIES-1:0] grn_vld_r;
  logic [bmp4_pkg::PAL_ENTRIES-1:0] blu_vld_r;

  bmp4_pkg::rgb_t rd_hi_r;
  bmp4_pkg::rgb_t rd_lo_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      case (wr.comp)
        bmp4_pkg::COMP_BLUE:  blu_mem[wr.idx] <= wr.data;
        bmp4_pkg::COMP_GREEN: grn_mem[wr.idx] <= wr.data;
        bmp4_pkg::COMP_RED:   red_mem[wr.idx] <= wr.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || wr.clr) begin
      red_vld_r <= '0;
      grn_vld_r <= '0;
      blu_vld_r <= '0;
    end else if (wr.en) begin
      case (wr.comp)
        bmp4_pkg::COMP_BLUE:  blu_vld_r[wr.idx] <= 1'b1;
        bmp4_pkg::COMP_GREEN: grn_vld_r[wr.idx] <= 1'b1;
        bmp4_pkg::COMP_RED:   red_vld_r[wr.idx] <= 1'b1;
        default: ;
      endcase
    end
  end

  // never-written components read as zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_hi_r.red   <= red_vld_r[rd_addr_hi] ? red_mem[rd_addr_hi] : 8'd0;
      rd_hi_r.green <= grn_vld_r[rd_addr_hi] ? grn_mem[rd_addr_hi] : 8'd0;
      rd_hi_r.blue  <= blu_vld_r[rd_addr_hi] ? blu_mem[rd_addr_hi] : 8'd0;
      rd_lo_r.red   <= red_vld_r[rd_addr_lo] ? red_mem[rd_addr_lo] : 8'd0;
      rd_lo_r.green <= grn_vld_r[rd_addr_lo] ? grn_mem[rd_addr_lo] : 8'd0;
      rd_lo_r.blue  <= blu_vld_r[rd_addr_lo] ? blu_mem[rd_addr_lo] : 8'd0;
    end
  end

  assign rd_hi = rd_hi_r;
  assign rd_lo = rd_lo_r;

endmodule

// ===== design/bmp4_parse.sv =====
// header parser and pixel expander, one byte per fire
module bmp4_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              file_start,
  input  bmp4_pkg::rgb_t    rgb_hi,
  input  bmp4_pkg::rgb_t    rgb_lo,
  output bmp4_pkg::pal_wr_t pal_wr,
  output logic [1:0]        res_n,
  output bmp4_pkg::res_t    res0,
  output bmp4_pkg::res_t    res1
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  localparam logic [6:0] PAL_START_7 = bmp4_pkg::PAL_START[6:0];

  logic [31:0] off_r, off_nxt, off_cur;
  logic [31:0] shift_r, shift_nxt, shift_cur;
  logic [31:0] ds_r, ds_nxt, ds_cur;
  logic [12:0] w_r, w_nxt, w_cur;
  logic [12:0] h_r, h_nxt, h_cur;
  logic [11:0] fr_r, fr_nxt, fr_cur;
  logic [11:0] rb_r, rb_nxt, rb_cur;
  logic [1:0]  ph_r, ph_nxt, ph_cur;
  logic        sb_r, sb_nxt, sb_cur;

  logic [6:0]  rel;
  logic [12:0] w_inc;
  logic [11:0] half;
  logic [12:0] row_size;
  logic [11:0] px;
  logic [12:0] px_inc;
  logic [11:0] py;
  logic        two;
  logic        last_byte;
  logic [12:0] rb_inc;
  logic [12:0] fr_inc;

  always_comb begin
    off_cur   = file_start ? 32'd0 : off_r;
    shift_cur = file_start ? 32'd0 : shift_r;
    ds_cur    = file_start ? 32'd0 : ds_r;
    w_cur     = file_start ? 13'd0 : w_r;
    h_cur     = file_start ? 13'd0 : h_r;
    fr_cur    = file_start ? 12'd0 : fr_r;
    rb_cur    = file_start ? 12'd0 : rb_r;
    ph_cur    = file_start ? PH_HEADER : ph_r;
    sb_cur    = file_start ? 1'b0 : sb_r;

    off_nxt   = off_cur;
    shift_nxt = shift_cur;
    ds_nxt    = ds_cur;
    w_nxt     = w_cur;
    h_nxt     = h_cur;
    fr_nxt    = fr_cur;
    rb_nxt    = rb_cur;
    ph_nxt    = ph_cur;
    sb_nxt    = sb_cur;

    pal_wr      = '0;
    pal_wr.clr  = fire && file_start;
    pal_wr.data = data_byte;
    res_n       = 2'd0;
    res0        = '0;
    res1        = '0;

    rel    = off_cur[6:0] - PAL_START_7;
    w_inc  = w_cur + 13'd1;
    half   = w_inc[12:1];
    row_size = ({1'b0, half} + 13'd3) & ~13'd3;
    px     = {rb_cur[10:0], 1'b0};
    px_inc = {1'b0, px} + 13'd1;
    py     = h_cur[11:0] - 12'd1 - fr_cur;
    two    = px_inc < w_cur;
    last_byte = ({1'b0, fr_cur} == h_cur - 13'd1) && (rb_cur == half - 12'd1);
    rb_inc = {1'b0, rb_cur} + 13'd1;
    fr_inc = {1'b0, fr_cur} + 13'd1;

    res0.image_width  = w_cur;
    res0.image_height = h_cur;
    res0.run_last     = 1'b1;
    res1.image_width  = w_cur;
    res1.image_height = h_cur;
    res1.run_last     = 1'b1;

    case (ph_cur)
      PH_HEADER: begin
        shift_nxt = {data_byte, shift_cur[31:8]};
        off_nxt   = off_cur + 32'd1;
        if (off_cur == 32'd1) begin
          if (shift_nxt[31:16] != bmp4_pkg::MAGIC_WORD) begin
            res0.kind = bmp4_pkg::KIND_BAD_MAGIC;
            res_n     = 2'd1;
            ph_nxt    = PH_DONE;
          end
        end else if (off_cur == 32'd13) begin
          ds_nxt = shift_nxt;
        end else if (off_cur == 32'd21) begin
          if (bmp4_pkg::dim_ok(shift_nxt)) w_nxt = shift_nxt[12:0];
          else sb_nxt = 1'b1;
        end else if (off_cur == 32'd25) begin
          if (bmp4_pkg::dim_ok(shift_nxt)) h_nxt = shift_nxt[12:0];
          else sb_nxt = 1'b1;
        end else if (off_cur == 32'd29) begin
          res_n  = 2'd1;
          ph_nxt = PH_DONE;
          if (shift_nxt[31:16] != bmp4_pkg::BIT_COUNT) begin
            res0.kind = bmp4_pkg::KIND_BAD_DEPTH;
          end else if (sb_cur) begin
            res0.kind = bmp4_pkg::KIND_BAD_SIZE;
          end else if (ds_cur < bmp4_pkg::HEADER_END) begin
            res0.kind = bmp4_pkg::KIND_BAD_OFFSET;
          end else begin
            res_n  = 2'd0;
            ph_nxt = PH_HEADER;
          end
        end else if (off_cur >= bmp4_pkg::PAL_START && off_cur < bmp4_pkg::HEADER_END) begin
          pal_wr.en   = fire && (rel[1:0] != 2'd3);
          pal_wr.comp = rel[1:0];
          pal_wr.idx  = rel[2 +: bmp4_pkg::PAL_AW];
        end
        if (off_cur == bmp4_pkg::HEADER_END - 32'd1) ph_nxt = PH_DATA;
      end
      PH_DATA: begin
        if (off_cur < ds_cur) begin
          off_nxt = off_cur + 32'd1;
        end else begin
          if (rb_cur < half) begin
            res0.kind       = bmp4_pkg::KIND_PIXEL;
            res0.pixel_x    = px;
            res0.pixel_y    = py;
            res0.color      = rgb_hi;
            res0.run_last   = !two;
            res0.image_last = !two && last_byte;
            res1.kind       = bmp4_pkg::KIND_PIXEL;
            res1.pixel_x    = px_inc[11:0];
            res1.pixel_y    = py;
            res1.color      = rgb_lo;
            res1.image_last = last_byte;
            res_n           = two ? 2'd2 : 2'd1;
          end
          if (rb_cur < half && last_byte) begin
            ph_nxt = PH_DONE;
          end else if (rb_inc >= row_size) begin
            rb_nxt = 12'd0;
            fr_nxt = fr_inc[11:0];
            if (fr_inc >= h_cur) ph_nxt = PH_DONE;
          end else begin
            rb_nxt = rb_inc[11:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      shift_r <= '0;
      ds_r    <= '0;
      w_r     <= '0;
      h_r     <= '0;
      fr_r    <= '0;
      rb_r    <= '0;
      ph_r    <= PH_HEADER;
      sb_r    <= 1'b0;
    end else if (fire) begin
      off_r   <= off_nxt;
      shift_r <= shift_nxt;
      ds_r    <= ds_nxt;
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      fr_r    <= fr_nxt;
      rb_r    <= rb_nxt;
      ph_r    <= ph_nxt;
      sb_r    <= sb_nxt;
    end
  end

endmodule

// ===== design/bmp4_outbuf.sv =====
// two-slot result register, hands out one result per cycle while out_ready is high
module bmp4_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic [1:0]          load_n,
  input  bmp4_pkg::res_t      load_res0,
  input  bmp4_pkg::res_t      load_res1,
  input  logic                out_ready,
  output logic                out_valid,
  output bmp4_pkg::res_t      out_res,
  output bmp4_pkg::buf_stat_t stat
);

  bmp4_pkg::res_t slot0_r;
  bmp4_pkg::res_t slot1_r;
  logic [1:0]     cnt_r;
  logic           out_fire;

  assign out_fire  = (cnt_r != 2'd0) && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = slot0_r;
  assign stat.cnt  = cnt_r;
  assign stat.free = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (load) begin
      slot0_r <= load_res0;
      slot1_r <= load_res1;
    end else if (out_fire && (cnt_r == 2'd2)) begin
      slot0_r <= slot1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= load_n;
    end else if (out_fire) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

// ===== design/bmp4_palette_pixel_decoder.sv =====
// top level of the 4-bit palette bmp decoder
// path: a taken byte is held in the input register with its palette read, then moves to
// the result register once that has room, from which its first result can be taken
// throughput: one byte per cycle while out_tready is high; a byte that yields two pixels
// holds back the next byte until the single result port hands out its second pixel
// reset: synchronous active-low rst_n clears parser state, palette and buffers
module bmp4_palette_pixel_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // file_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // pixel_x, pixel_y, red, green, blue, image_width,
                                  // image_height, zero fill
  output logic [3:0]  out_tuser,  // kind, run_last
  output logic        out_tlast   // image_last
);

  logic                in_fire;
  logic                s0_vld_r;
  logic [7:0]          s0_byte_r;
  logic                s0_start_r;
  logic                proc_fire;

  bmp4_pkg::rgb_t      rgb_hi;
  bmp4_pkg::rgb_t      rgb_lo;
  bmp4_pkg::pal_wr_t   pal_wr;
  logic [1:0]          res_n;
  bmp4_pkg::res_t      res0;
  bmp4_pkg::res_t      res1;
  bmp4_pkg::res_t      out_res;
  bmp4_pkg::buf_stat_t stat;

  assign proc_fire = s0_vld_r && stat.free;
  assign in_tready = !s0_vld_r || proc_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (in_tready) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_byte_r  <= in_tdata;
      s0_start_r <= in_tuser;
    end
  end

  bmp4_palette u_pal (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (pal_wr),
    .rd_en      (in_fire),
    .rd_addr_hi (in_tdata[7:4]),
    .rd_addr_lo (in_tdata[3:0]),
    .rd_hi      (rgb_hi),
    .rd_lo      (rgb_lo)
  );

  bmp4_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (proc_fire),
    .data_byte  (s0_byte_r),
    .file_start (s0_start_r),
    .rgb_hi     (rgb_hi),
    .rgb_lo     (rgb_lo),
    .pal_wr     (pal_wr),
    .res_n      (res_n),
    .res0       (res0),
    .res1       (res1)
  );

  bmp4_outbuf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (proc_fire),
    .load_n    (res_n),
    .load_res0 (res0),
    .load_res1 (res1),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_res   (out_res),
    .stat      (stat)
  );

  assign out_tdata = {6'd0, out_res.image_height, out_res.image_width,
                      out_res.color.blue, out_res.color.green, out_res.color.red,
                      out_res.pixel_y, out_res.pixel_x};
  assign out_tuser = {out_res.run_last, out_res.kind};
  assign out_tlast = out_res.image_last;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.cnt != 2'd3)
    else $error("result buffer count out of range");

  a_flag_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:0] != bmp4_pkg::KIND_PIXEL) |-> out_tuser[3] && !out_tlast)
    else $error("flag result not marked as last of its byte");

  a_image_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[3])
    else $error("image end not on last result of a byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");
`endif

endmodule
